// File: src/piecewise_linear_curve_lookup_unit_assert.svh
// Assertion macros shared by the curve lookup RTL
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PLC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PLC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define PLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/plc_pkg.sv
// Types and constants of the curve lookup pipeline
`default_nettype none
package plc_pkg;
   localparam int VALUE_W            = 32;
   localparam int POINT_W            = 32;
   localparam int XW                 = 16;
   localparam int YW                 = 16;
   localparam int DIFF_W             = 17;
   localparam int PROD_W             = 34;
   localparam int MAG_W              = 32;
   localparam int DIV_W              = 16;
   localparam int RESULT_W           = 17;
   localparam int HALF_W             = RESULT_W + 1;
   localparam int RESULT_OFFSET      = 256;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES         = MAG_W / DIV_BITS_PER_STAGE;
   localparam int CSR_IDX_W          = 4;
   localparam int CSR_DATA_W         = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT0 = '0;

   // search result: differences for the interpolation
   typedef struct packed {
      logic signed [DIFF_W-1:0] dvx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dx;
      logic signed [YW-1:0]     base;
      logic                     direct;
      logic                     halve;
   } plc_diff_type;

   // unsigned division operands with sign and side data
   typedef struct packed {
      logic [MAG_W-1:0]     num;
      logic [DIV_W-1:0]     den;
      logic                 neg;
      logic signed [YW-1:0] base;
      logic                 direct;
      logic                 halve;
   } plc_div_type;
endpackage
`default_nettype wire

// File: src/plc_front.sv
// Clamp stage and segment search stage of the curve lookup
`default_nettype none
module plc_front #(
   parameter int NUM_POINTS = 5
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic signed [plc_pkg::VALUE_W-1:0]            in_value,
   input  logic                                          in_halve,
   input  logic [NUM_POINTS-1:0][plc_pkg::POINT_W-1:0]   point,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output plc_pkg::plc_diff_type                         out_data
);
   import plc_pkg::*;

   logic signed [XW-1:0] x_c [NUM_POINTS];
   logic signed [YW-1:0] y_c [NUM_POINTS];

   logic                 s1_valid_ff;
   logic signed [XW-1:0] s1_v_ff;
   logic signed [XW-1:0] s1_v_in;
   logic                 s1_halve_ff;
   logic                 s1_ready;
   logic                 s2_ready;

   logic signed [XW-1:0] xk;
   logic signed [YW-1:0] yk;
   logic signed [XW-1:0] xp;
   logic signed [YW-1:0] yp;
   logic                 found;
   logic                 above;
   logic                 out_valid_ff;
   plc_diff_type         out_data_ff;
   plc_diff_type         out_data_in;

   // split the points into x and y
   always_comb begin
      for (int i = 0; i < NUM_POINTS; i++) begin
         x_c[i] = point[i][POINT_W-1 -: XW];
         y_c[i] = point[i][YW-1:0];
      end
   end

   assign s2_ready = ~out_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   // clamp the value to the curve's x span
   always_comb begin
      if (in_value > VALUE_W'(x_c[0])) begin
         s1_v_in = x_c[0];
      end else if (in_value < VALUE_W'(x_c[NUM_POINTS-1])) begin
         s1_v_in = x_c[NUM_POINTS-1];
      end else begin
         s1_v_in = in_value[XW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_ready) begin
         s1_v_ff     <= s1_v_in;
         s1_halve_ff <= in_halve;
      end
   end

   // find the first point below the value, from index 1
   always_comb begin
      xk    = x_c[NUM_POINTS-1];
      yk    = y_c[NUM_POINTS-1];
      xp    = x_c[NUM_POINTS-2];
      yp    = y_c[NUM_POINTS-2];
      found = 1'b0;
      for (int k = NUM_POINTS - 1; k >= 1; k--) begin
         if (s1_v_ff > x_c[k]) begin
            found = 1'b1;
            xk    = x_c[k];
            yk    = y_c[k];
            xp    = x_c[k-1];
            yp    = y_c[k-1];
         end
      end
      above              = s1_v_ff > x_c[0];
      out_data_in.dvx    = DIFF_W'(s1_v_ff) - DIFF_W'(xk);
      out_data_in.dy     = DIFF_W'(yp) - DIFF_W'(yk);
      out_data_in.dx     = DIFF_W'(xp) - DIFF_W'(xk);
      out_data_in.base   = above ? y_c[0] : yk;
      out_data_in.direct = above | ~found;
      out_data_in.halve  = s1_halve_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (s2_ready) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
endmodule
`default_nettype wire

// File: src/plc_mul.sv
// Product stage and magnitude stage ahead of the divider
`default_nettype none
module plc_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  plc_pkg::plc_diff_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output plc_pkg::plc_div_type  out_data
);
   import plc_pkg::*;

   logic                     a_valid_ff;
   logic signed [PROD_W-1:0] a_prod_ff;
   logic signed [PROD_W-1:0] a_prod_in;
   logic signed [DIFF_W-1:0] a_dx_ff;
   logic signed [YW-1:0]     a_base_ff;
   logic                     a_direct_ff;
   logic                     a_halve_ff;
   logic                     a_ready;
   logic                     b_ready;
   logic                     out_valid_ff;
   plc_div_type              out_data_ff;
   plc_div_type              out_data_in;

   assign b_ready  = ~out_valid_ff | out_ready;
   assign a_ready  = ~a_valid_ff | b_ready;
   assign in_ready = a_ready;

   // exact signed product of offset and y difference
   assign a_prod_in = in_data.dvx * in_data.dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready) begin
         a_prod_ff   <= a_prod_in;
         a_dx_ff     <= in_data.dx;
         a_base_ff   <= in_data.base;
         a_direct_ff <= in_data.direct;
         a_halve_ff  <= in_data.halve;
      end
   end

   // take magnitudes; a zero x difference yields the point's y directly
   always_comb begin
      out_data_in.num    = a_prod_ff[PROD_W-1] ? MAG_W'(-a_prod_ff) : MAG_W'(a_prod_ff);
      out_data_in.den    = a_dx_ff[DIFF_W-1] ? DIV_W'(-a_dx_ff) : DIV_W'(a_dx_ff);
      out_data_in.neg    = a_prod_ff[PROD_W-1] ^ a_dx_ff[DIFF_W-1];
      out_data_in.base   = a_base_ff;
      out_data_in.direct = a_direct_ff | (a_dx_ff == '0);
      out_data_in.halve  = a_halve_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (b_ready) begin
         out_valid_ff <= a_valid_ff;
      end
      if (b_ready) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
endmodule
`default_nettype wire

// File: src/plc_div.sv
// Pipelined restoring divider, a few quotient bits per stage
`default_nettype none
module plc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  plc_pkg::plc_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output plc_pkg::plc_div_type out_data
);
   import plc_pkg::*;

   logic [DIV_STAGES-1:0] vld_ff;
   logic [DIV_STAGES-1:0] rdy;
   logic [DIV_W-1:0]      rem_ff [DIV_STAGES];
   plc_div_type           st_ff  [DIV_STAGES];

   // num carries dividend bits out the top and quotient bits in at the bottom
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic             prev_vld;
      logic             next_rdy;
      logic [DIV_W-1:0] prev_rem;
      plc_div_type      prev_st;
      logic [DIV_W-1:0] rem_in;
      plc_div_type      st_in;

      if (s == 0) begin : g_first
         assign prev_vld = in_valid;
         assign prev_rem = '0;
         assign prev_st  = in_data;
      end else begin : g_rest
         assign prev_vld = vld_ff[s-1];
         assign prev_rem = rem_ff[s-1];
         assign prev_st  = st_ff[s-1];
      end

      if (s == DIV_STAGES - 1) begin : g_last
         assign next_rdy = out_ready;
      end else begin : g_mid
         assign next_rdy = rdy[s+1];
      end

      assign rdy[s] = ~vld_ff[s] | next_rdy;

      // shift, compare and subtract once per quotient bit
      always_comb begin
         logic [DIV_W:0] trial;
         st_in  = prev_st;
         rem_in = prev_rem;
         for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
            trial     = {rem_in, st_in.num[MAG_W-1]};
            st_in.num = {st_in.num[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, prev_st.den}) begin
               trial        = trial - {1'b0, prev_st.den};
               st_in.num[0] = 1'b1;
            end
            rem_in = trial[DIV_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= prev_vld;
         end
         if (rdy[s]) begin
            rem_ff[s] <= rem_in;
            st_ff[s]  <= st_in;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_data  = st_ff[DIV_STAGES-1];
endmodule
`default_nettype wire

// File: src/plc_back.sv
// Sign restore, offset add, halving and output register
`default_nettype none
module plc_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  plc_pkg::plc_div_type                 in_data,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [plc_pkg::RESULT_W-1:0]  out_result
);
   import plc_pkg::*;

   logic [PROD_W-1:0]          q_ext;
   logic signed [PROD_W-1:0]   q_s;
   logic signed [PROD_W-1:0]   y_s;
   logic                       f_valid_ff;
   logic [HALF_W-1:0]          f_ylo_ff;
   logic                       f_sign_ff;
   logic                       f_halve_ff;
   logic                       f_ready;
   logic                       o_ready;
   logic [HALF_W-1:0]          rounded;
   logic [RESULT_W-1:0]        half;
   logic                       out_valid_ff;
   logic signed [RESULT_W-1:0] out_result_ff;
   logic signed [RESULT_W-1:0] out_result_in;

   assign o_ready  = ~out_valid_ff | out_ready;
   assign f_ready  = ~f_valid_ff | o_ready;
   assign in_ready = f_ready;

   // apply the quotient's sign and add the segment's y
   always_comb begin
      q_ext = {{(PROD_W - MAG_W){1'b0}}, in_data.num};
      q_s   = in_data.neg ? -q_ext : q_ext;
      y_s   = in_data.direct ? PROD_W'(in_data.base) : q_s + PROD_W'(in_data.base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (f_ready) begin
         f_valid_ff <= in_valid;
      end
      if (f_ready) begin
         f_ylo_ff   <= y_s[HALF_W-1:0];
         f_sign_ff  <= y_s[PROD_W-1];
         f_halve_ff <= in_data.halve;
      end
   end

   // halve toward zero: add one to negatives, then shift
   always_comb begin
      rounded       = f_ylo_ff + HALF_W'(f_sign_ff);
      half          = f_halve_ff ? rounded[HALF_W-1:1] : f_ylo_ff[RESULT_W-1:0];
      out_result_in = half + RESULT_W'(RESULT_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (o_ready) begin
         out_valid_ff <= f_valid_ff;
      end
      if (o_ready) begin
         out_result_ff <= out_result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;
endmodule
`default_nettype wire

// File: src/piecewise_linear_curve_lookup_unit.sv
// Stages from an accepted req beat to rsp_valid: clamp, search, product,
// magnitude, 8 divider stages of 4 quotient bits, sign/add, output.
// Throughput: one beat per cycle; every stage has its own valid bit and
// holds under backpressure while emptier stages ahead keep filling.
// Reset clears all valid bits and sets every curve point to zero.
`default_nettype none
`include "piecewise_linear_curve_lookup_unit_assert.svh"
module piecewise_linear_curve_lookup_unit #(
   parameter int NUM_POINTS = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [plc_pkg::VALUE_W-1:0]     req_value,
   input  logic                                   req_halve,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [plc_pkg::RESULT_W-1:0]    rsp_result,
   input  logic                                   csr_write_en,
   input  logic [plc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [plc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import plc_pkg::*;

   logic [NUM_POINTS-1:0][POINT_W-1:0] point_ff;

   logic         fr_valid;
   logic         fr_ready;
   plc_diff_type fr_data;
   logic         mu_valid;
   logic         mu_ready;
   plc_div_type  mu_data;
   logic         dv_valid;
   logic         dv_ready;
   plc_div_type  dv_data;

   // curve point registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff <= '0;
      end else if (csr_write_en) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               point_ff[i] <= csr_wdata[POINT_W-1:0];
            end
         end
      end
   end

   plc_front #(
      .NUM_POINTS (NUM_POINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_value  (req_value),
      .in_halve  (req_halve),
      .point     (point_ff),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   plc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (mu_valid),
      .out_ready (mu_ready),
      .out_data  (mu_data)
   );

   plc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mu_valid),
      .in_ready  (mu_ready),
      .in_data   (mu_data),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (dv_data)
   );

   plc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_ready   (dv_ready),
      .in_data    (dv_data),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (rsp_result)
   );

   // an empty output stage lets the whole pipe take a beat
   `PLC_ASSERT_IMPLY(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "pipe stalled while output empty")
   // nothing comes out right after reset
   `PLC_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $fell(reset), !rsp_valid, "result present after reset")
   // a write to the first point lands in its register
   `PLC_ASSERT_NEXT(a_point0_write, clock, reset, csr_write_en && csr_index == CSR_POINT0, point_ff[0] == $past(csr_wdata), "point 0 write lost")
endmodule
`default_nettype wire
